/* hw/rtl/gaap_pkg.sv */
`default_nettype none
// ============================================================================
// gaap_pkg - shared types and constants of the GPIB address argument parser
// Beat layouts of both channels, character codes and address limits.
// ============================================================================
package gaap_pkg;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Decimal accumulation
    localparam int unsigned DEC_RADIX = 10;

    // Address limits
    localparam logic [4:0] PRIMARY_MAX   = 5'd30;
    localparam logic [4:0] PRIMARY_SAT   = 5'd31;
    localparam logic [6:0] SECONDARY_MIN = 7'd96;
    localparam logic [6:0] SECONDARY_MAX = 7'd126;
    localparam logic [6:0] SECONDARY_SAT = 7'd127;

    // One character of argument text
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_last;
    } gaap_char_t;

    // One parse result
    typedef struct packed {
        logic       ok;
        logic [4:0] primary_addr;
        logic       has_secondary;
        logic [6:0] secondary_addr;
    } gaap_result_t;

endpackage : gaap_pkg
`default_nettype wire

/* hw/rtl/gaap_in_stage.sv */
`default_nettype none
// ============================================================================
// gaap_in_stage - input register of the parser
// Hold one character beat; refill when empty or whenever the held beat moves on.
// ============================================================================
module gaap_in_stage
    import gaap_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire gaap_char_t char_beat,
    input  wire logic       advance,
    output logic            hold_valid,
    output gaap_char_t      hold_beat
);

    logic       valid_reg;
    logic       valid_next;
    gaap_char_t beat_reg;
    logic       load;

    // Take a new beat when empty or when the held beat leaves this cycle
    assign load       = !valid_reg || advance;
    assign char_stall = !load;
    assign valid_next = load ? char_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && char_valid)
        begin
            beat_reg <= char_beat;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_beat  = beat_reg;

endmodule : gaap_in_stage
`default_nettype wire

/* hw/rtl/gaap_parse_core.sv */
`default_nettype none
// ============================================================================
// gaap_parse_core - per-character parse state and result logic
// Advance the phase machine and the saturating accumulators by one character.
// ============================================================================
module gaap_parse_core
    import gaap_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire gaap_char_t hold_beat,
    output gaap_result_t    result
);

    typedef enum logic [4:0] {
        PH_LEAD = 5'b00001,
        PH_PRIM = 5'b00010,
        PH_GAP  = 5'b00100,
        PH_SEC  = 5'b01000,
        PH_TAIL = 5'b10000
    } gaap_phase_t;

    gaap_phase_t phase_reg, phase_next, phase_upd;
    logic        failed_reg, failed_next, failed_upd;
    logic [4:0]  primary_reg, primary_next, primary_upd;
    logic [6:0]  secondary_reg, secondary_next, secondary_upd;
    logic        brk_seen_reg, brk_seen_next, brk_seen_upd;

    logic        is_digit;
    logic        is_space;
    logic        is_brk;
    logic [3:0]  digit_val;
    logic [8:0]  primary_sum;
    logic [10:0] secondary_sum;
    logic [4:0]  primary_acc;
    logic [6:0]  secondary_acc;
    logic        ok_base;
    logic        has_sec;
    logic        ok;

    assign is_digit  = (hold_beat.text_char >= CHAR_ZERO) && (hold_beat.text_char <= CHAR_NINE);
    assign is_space  = (hold_beat.text_char == CHAR_SPACE);
    assign is_brk    = (hold_beat.text_char == CHAR_CR) || (hold_beat.text_char == CHAR_LF);
    assign digit_val = is_digit ? 4'(hold_beat.text_char - CHAR_ZERO) : 4'd0;

    // Multiply-accumulate, then clamp
    assign primary_sum   = 9'(primary_reg) * 9'(DEC_RADIX) + 9'(digit_val);
    assign secondary_sum = 11'(secondary_reg) * 11'(DEC_RADIX) + 11'(digit_val);
    assign primary_acc   = (primary_sum > 9'(PRIMARY_SAT)) ? PRIMARY_SAT : primary_sum[4:0];
    assign secondary_acc = (secondary_sum > 11'(SECONDARY_SAT)) ? SECONDARY_SAT
                                                                : secondary_sum[6:0];

    always_comb
    begin
        phase_upd     = phase_reg;
        failed_upd    = failed_reg;
        primary_upd   = primary_reg;
        secondary_upd = secondary_reg;
        brk_seen_upd  = brk_seen_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (is_digit)
                begin
                    primary_upd = 5'(digit_val);
                    phase_upd   = PH_PRIM;
                end
                else if (!is_space)
                begin
                    failed_upd = 1'b1;
                end
            end
            PH_PRIM:
            begin
                if (is_digit)
                begin
                    primary_upd = primary_acc;
                end
                else if (is_space || is_brk)
                begin
                    phase_upd    = PH_GAP;
                    brk_seen_upd = is_brk;
                end
                else
                begin
                    failed_upd = 1'b1;
                end
            end
            PH_GAP:
            begin
                if (is_space || is_brk)
                begin
                    brk_seen_upd = brk_seen_reg || is_brk;
                end
                else if (is_digit && !brk_seen_reg)
                begin
                    secondary_upd = 7'(digit_val);
                    phase_upd     = PH_SEC;
                end
                else
                begin
                    failed_upd = 1'b1;
                end
            end
            PH_SEC:
            begin
                if (is_digit)
                begin
                    secondary_upd = secondary_acc;
                end
                else if (is_space || is_brk)
                begin
                    phase_upd    = PH_TAIL;
                    brk_seen_upd = is_brk;
                end
                else
                begin
                    failed_upd = 1'b1;
                end
            end
            PH_TAIL:
            begin
                if (is_space || is_brk)
                begin
                    brk_seen_upd = brk_seen_reg || is_brk;
                end
                else
                begin
                    failed_upd = 1'b1;
                end
            end
            default:
            begin
                failed_upd = 1'b1;
            end
        endcase
    end

    // Judge the line on the state as updated by its last character
    assign has_sec = (phase_upd == PH_SEC) || (phase_upd == PH_TAIL);
    assign ok_base = !failed_upd && (phase_upd != PH_LEAD) && (primary_upd <= PRIMARY_MAX);
    assign ok      = ok_base && (!has_sec ||
                     ((secondary_upd >= SECONDARY_MIN) && (secondary_upd <= SECONDARY_MAX)));

    assign result.ok             = ok;
    assign result.primary_addr   = ok ? primary_upd : 5'd0;
    assign result.has_secondary  = ok && has_sec;
    assign result.secondary_addr = (ok && has_sec) ? secondary_upd : 7'd0;

    // Start over after the last character of a line
    always_comb
    begin
        phase_next     = phase_reg;
        failed_next    = failed_reg;
        primary_next   = primary_reg;
        secondary_next = secondary_reg;
        brk_seen_next  = brk_seen_reg;
        if (advance)
        begin
            if (hold_beat.is_last)
            begin
                phase_next     = PH_LEAD;
                failed_next    = 1'b0;
                primary_next   = 5'd0;
                secondary_next = 7'd0;
                brk_seen_next  = 1'b0;
            end
            else
            begin
                phase_next     = phase_upd;
                failed_next    = failed_upd;
                primary_next   = primary_upd;
                secondary_next = secondary_upd;
                brk_seen_next  = brk_seen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            failed_reg    <= 1'b0;
            primary_reg   <= 5'd0;
            secondary_reg <= 7'd0;
            brk_seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            primary_reg   <= primary_next;
            secondary_reg <= secondary_next;
            brk_seen_reg  <= brk_seen_next;
        end
    end

endmodule : gaap_parse_core
`default_nettype wire

/* hw/rtl/gaap_out_stage.sv */
`default_nettype none
// ============================================================================
// gaap_out_stage - result register of the parser
// Hold a finished result until the downstream side takes the beat.
// ============================================================================
module gaap_out_stage
    import gaap_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire gaap_result_t result,
    output logic              room,
    output logic              result_valid,
    input  wire logic         result_stall,
    output gaap_result_t      result_beat
);

    logic         valid_reg;
    logic         valid_next;
    gaap_result_t beat_reg;

    assign room = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign result_beat  = beat_reg;

endmodule : gaap_out_stage
`default_nettype wire

/* hw/rtl/gpib_address_argument_parser_unit.sv */
// A line's result is registered as its last character is taken and is valid in the next cycle.
// Throughput: one character per cycle; the input register and the result register
//   each hold one beat, so a waiting result blocks input only behind a last character.
// A last character waits in the input register only while the result register
//   is full and stalled.
// Reset (rst_n, async, active low) empties both registers and returns the parse
//   state to the leading-spaces phase.
`default_nettype none
// ============================================================================
// gpib_address_argument_parser_unit - GPIB address argument parser
// Parse "primary [secondary]" address text one character per beat and emit
// one result beat per line.
// ============================================================================
module gpib_address_argument_parser_unit
    import gaap_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Character channel
    input  wire logic         char_valid,
    output logic              char_stall,
    input  wire gaap_char_t   char_beat,
    // Result channel
    output logic              result_valid,
    input  wire logic         result_stall,
    output gaap_result_t      result_beat
);

    logic         hold_valid;
    gaap_char_t   hold_beat;
    logic         advance;
    logic         room;
    logic         load_result;
    gaap_result_t result;

    // Input register: one character beat ahead of the parse logic
    gaap_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_beat  (char_beat),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_beat  (hold_beat)
    );

    // Consume the held character; a last character also needs a free result slot
    assign advance     = hold_valid && (!hold_beat.is_last || room);
    assign load_result = advance && hold_beat.is_last;

    // Parse state update and line verdict
    gaap_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .hold_beat (hold_beat),
        .result    (result)
    );

    // Result register toward the downstream side
    gaap_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load_result),
        .result       (result),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    // A rejected line carries all fields clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_beat.ok) |->
            (result_beat.primary_addr == 5'd0 && !result_beat.has_secondary &&
             result_beat.secondary_addr == 7'd0))
        else $error("rejected result carries nonzero fields");

    // An accepted line stays in the legal address ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_beat.ok) |->
            (result_beat.primary_addr <= PRIMARY_MAX &&
             (!result_beat.has_secondary ||
              (result_beat.secondary_addr >= SECONDARY_MIN &&
               result_beat.secondary_addr <= SECONDARY_MAX))))
        else $error("accepted result out of address range");

    // A last character never moves on while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid && hold_beat.is_last && result_valid && result_stall) |->
            !advance)
        else $error("last character consumed into a full result register");

    // Each consumed last character yields a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> result_valid)
        else $error("result beat lost after last character");

endmodule : gpib_address_argument_parser_unit
`default_nettype wire
